### sv/ltrg_pkg.sv
// package for the led twinkle ramp generator: sizes, constants and the stage type
`default_nettype none
package ltrg_pkg;

    localparam int CHANNELS = 4;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CH_W    = 2;
    localparam int STEP_W  = 12;
    localparam int TOP_W   = 8;
    localparam int NBOT_W  = 6;
    localparam int LEVEL_W = 8;
    localparam int ACC_W   = 16;

    localparam logic [ACC_W-1:0] ACC_FULL = '1;
    localparam logic [ACC_W-1:0] ACC_ZERO = '0;

    // ramp state after the update, carried to the scaling stage
    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic               in_range;
        logic [ACC_W-1:0]   acc;
        logic [TOP_W-1:0]   top;
        logic [LEVEL_W-1:0] bot;
        logic               rising;
    } ramp_t;

endpackage
`default_nettype wire

### sv/ltrg_scale.sv
// maps a ramp value onto the range between bottom and top brightness
`default_nettype none
module ltrg_scale (
    input  wire ltrg_pkg::ramp_t            ramp,
    output logic [ltrg_pkg::LEVEL_W-1:0]    level
);
    import ltrg_pkg::*;

    logic signed [TOP_W:0] diff;
    logic                  neg;
    logic [TOP_W-1:0]      mag;
    logic [ACC_W+TOP_W-1:0] prod;
    logic [TOP_W-1:0]      q_hi;
    logic [ACC_W:0]        rem_raw;
    logic                  wrap;
    logic [ACC_W:0]        rem;
    logic [TOP_W-1:0]      quot;
    logic                  exact;
    logic [LEVEL_W-1:0]    scaled;

    always_comb begin
        diff = $signed({1'b0, ramp.top}) - $signed({1'b0, ramp.bot});
        neg  = diff[TOP_W];
        mag  = neg ? TOP_W'(-diff) : diff[TOP_W-1:0];
        prod = ramp.acc * mag;
        // x = hi*65536 + lo = hi*65535 + (hi + lo), and hi + lo stays below 2*65535
        q_hi    = prod[ACC_W+TOP_W-1:ACC_W];
        rem_raw = {1'b0, prod[ACC_W-1:0]} + {{(ACC_W+1-TOP_W){1'b0}}, q_hi};
        wrap    = rem_raw >= {1'b0, ACC_FULL};
        rem     = wrap ? rem_raw - {1'b0, ACC_FULL} : rem_raw;
        quot    = wrap ? q_hi + TOP_W'(1) : q_hi;
        exact   = (rem == '0);
        // negative spread rounds toward minus infinity
        if (neg) begin
            scaled = ramp.bot - LEVEL_W'(quot) - LEVEL_W'(!exact);
        end else begin
            scaled = ramp.bot + LEVEL_W'(quot);
        end
        level = ramp.in_range ? scaled : '0;
    end

endmodule
`default_nettype wire

### sv/led_twinkle_ramp_generator_unit.sv
// led twinkle ramp generator: per-channel triangle ramp with scaled level output
// path: a transaction passes the input register, the ramp state register and the
// output register in order; m_valid is the output register's valid, a stall holds it
// throughput: one transaction per cycle unless the output stalls; input register,
// ramp update, scaling register; the per-channel state is read and written back in
// the same cycle, so back-to-back transactions on one channel never wait
// reset: ramps go to zero and rising, pipeline empties; step, top and bottom stay
// undefined until a restart for that channel
`default_nettype none
module led_twinkle_ramp_generator_unit (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [ltrg_pkg::CH_W-1:0]        s_channel,
    input  wire                              s_restart,
    input  wire  [ltrg_pkg::STEP_W-1:0]      s_next_step,
    input  wire  [ltrg_pkg::TOP_W-1:0]       s_next_top,
    input  wire  [ltrg_pkg::NBOT_W-1:0]      s_next_bottom,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [ltrg_pkg::CH_W-1:0]        m_out_channel,
    output logic [ltrg_pkg::LEVEL_W-1:0]     m_level,
    output logic                             m_rising
);
    import ltrg_pkg::*;

    // pipeline valids
    logic in_vld_reg, mid_vld_reg, out_vld_reg;
    logic out_free, mid_free, in_free;
    logic in_load, mid_load, out_load;

    // input register
    logic [CH_W-1:0]   in_ch_reg;
    logic              in_restart_reg;
    logic [STEP_W-1:0] in_step_reg;
    logic [TOP_W-1:0]  in_top_reg;
    logic [NBOT_W-1:0] in_bot_reg;

    // per-channel state
    logic [ACC_W-1:0]   acc_reg  [CHANNELS];
    logic               up_reg   [CHANNELS];
    logic [STEP_W-1:0]  step_reg [CHANNELS];
    logic [TOP_W-1:0]   top_reg  [CHANNELS];
    logic [LEVEL_W-1:0] bot_reg  [CHANNELS];

    logic [CH_IDX_W-1:0] idx;
    logic                in_range;
    logic [ACC_W-1:0]    acc_cur;
    logic                up_cur;
    logic [STEP_W-1:0]   step_cur;
    logic [TOP_W-1:0]    top_cur;
    logic [LEVEL_W-1:0]  bot_cur;
    logic [ACC_W:0]      sum;
    logic                borrow;

    ramp_t ramp_next, mid_reg;
    logic [STEP_W-1:0] step_next;
    logic [LEVEL_W-1:0] level_next;

    logic [CH_W-1:0]    out_ch_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic               out_rising_reg;

    assign out_free = !out_vld_reg || m_ready;
    assign mid_free = !mid_vld_reg || out_free;
    assign in_free  = !in_vld_reg || mid_free;
    assign s_ready  = in_free;
    assign in_load  = s_valid && in_free;
    assign mid_load = in_vld_reg && mid_free;
    assign out_load = mid_vld_reg && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            mid_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_free) begin
                in_vld_reg <= s_valid;
            end
            if (mid_free) begin
                mid_vld_reg <= in_vld_reg;
            end
            if (out_free) begin
                out_vld_reg <= mid_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_ch_reg      <= s_channel;
            in_restart_reg <= s_restart;
            in_step_reg    <= s_next_step;
            in_top_reg     <= s_next_top;
            in_bot_reg     <= s_next_bottom;
        end
    end

    // ramp update
    always_comb begin
        idx      = CH_IDX_W'(in_ch_reg);
        in_range = (int'(in_ch_reg) < CHANNELS);
        acc_cur  = acc_reg[idx];
        up_cur   = up_reg[idx];
        step_cur = step_reg[idx];
        top_cur  = top_reg[idx];
        bot_cur  = bot_reg[idx];
        sum      = {1'b0, acc_cur} + {{(ACC_W+1-STEP_W){1'b0}}, step_cur};
        borrow   = acc_cur < {{(ACC_W-STEP_W){1'b0}}, step_cur};

        ramp_next.channel  = in_ch_reg;
        ramp_next.in_range = in_range;
        ramp_next.acc      = acc_cur;
        ramp_next.top      = top_cur;
        ramp_next.bot      = bot_cur;
        ramp_next.rising   = up_cur;
        step_next          = step_cur;

        if (in_restart_reg) begin
            ramp_next.acc    = ACC_ZERO;
            ramp_next.rising = 1'b1;
            ramp_next.top    = in_top_reg;
            ramp_next.bot    = LEVEL_W'(in_bot_reg);
            step_next        = in_step_reg;
        end else if (up_cur) begin
            if (sum[ACC_W]) begin
                // would overflow: pin at full and turn down
                ramp_next.acc    = ACC_FULL;
                ramp_next.rising = 1'b0;
                ramp_next.bot    = LEVEL_W'(in_bot_reg);
                step_next        = in_step_reg;
            end else begin
                ramp_next.acc = sum[ACC_W-1:0];
            end
        end else begin
            if (borrow) begin
                // would underflow: pin at zero and turn up
                ramp_next.acc    = ACC_ZERO;
                ramp_next.rising = 1'b1;
                ramp_next.top    = in_top_reg;
                step_next        = in_step_reg;
            end else begin
                ramp_next.acc = acc_cur - {{(ACC_W-STEP_W){1'b0}}, step_cur};
            end
        end

        if (!in_range) begin
            ramp_next.rising = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                acc_reg[i] <= ACC_ZERO;
                up_reg[i]  <= 1'b1;
            end
        end else if (mid_load && in_range) begin
            acc_reg[idx] <= ramp_next.acc;
            up_reg[idx]  <= ramp_next.rising;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_load && in_range) begin
            step_reg[idx] <= step_next;
            top_reg[idx]  <= ramp_next.top;
            bot_reg[idx]  <= ramp_next.bot;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_load) begin
            mid_reg <= ramp_next;
        end
    end

    ltrg_scale u_scale (
        .ramp  (mid_reg),
        .level (level_next)
    );

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_ch_reg     <= mid_reg.channel;
            out_level_reg  <= level_next;
            out_rising_reg <= mid_reg.rising;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_out_channel = out_ch_reg;
    assign m_level       = out_level_reg;
    assign m_rising      = out_rising_reg;

endmodule
`default_nettype wire

### sv/ltrg_checker.sv
// port-level checks for the led twinkle ramp generator, bound to the top level
`default_nettype none
module ltrg_port_checks (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_valid,
    input wire                          s_ready,
    input wire                          m_valid,
    input wire                          m_ready,
    input wire [ltrg_pkg::CH_W-1:0]     m_out_channel,
    input wire [ltrg_pkg::LEVEL_W-1:0]  m_level,
    input wire                          m_rising
);
    import ltrg_pkg::*;

    // transactions accepted but not yet delivered
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    always_comb begin
        inflight_next = inflight_reg + 3'(s_valid && s_ready) - 3'(m_valid && m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_channel) && $stable(m_level)
            && $stable(m_rising))
        else $error("stalled result changed or dropped");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != 3'd0)
        else $error("result without an accepted transaction");

    a_full_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg == 3'd3 && !m_ready |-> !s_ready)
        else $error("transaction accepted with full pipeline");

endmodule

bind led_twinkle_ramp_generator_unit ltrg_port_checks u_ltrg_port_checks (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_channel (m_out_channel),
    .m_level       (m_level),
    .m_rising      (m_rising)
);
`default_nettype wire

### bench/ltrg_checker.sv
// checker for the twinkle ramp generator: predicts each level and compares the results
module ltrg_checker (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_valid,
    input  wire                            s_ready,
    input  wire [ltrg_pkg::CH_W-1:0]       s_channel,
    input  wire                            s_restart,
    input  wire [ltrg_pkg::STEP_W-1:0]     s_next_step,
    input  wire [ltrg_pkg::TOP_W-1:0]      s_next_top,
    input  wire [ltrg_pkg::NBOT_W-1:0]     s_next_bottom,
    input  wire                            m_valid,
    input  wire                            m_ready,
    input  wire [ltrg_pkg::CH_W-1:0]       m_out_channel,
    input  wire [ltrg_pkg::LEVEL_W-1:0]    m_level,
    input  wire                            m_rising,
    output int                             fail_count,
    output int                             pending,
    output int                             result_count,
    output int                             turn_count
);

    typedef struct packed {
        logic [ltrg_pkg::CH_W-1:0]    channel;
        logic [ltrg_pkg::LEVEL_W-1:0] level;
        logic                         rising;
    } level_result_t;

    // per-channel ramp state, mirrored from what the block should hold
    logic [ltrg_pkg::ACC_W-1:0]   ramp_acc  [ltrg_pkg::CHANNELS];
    logic                         ramp_up   [ltrg_pkg::CHANNELS];
    logic [ltrg_pkg::STEP_W-1:0]  ramp_step [ltrg_pkg::CHANNELS];
    logic [ltrg_pkg::TOP_W-1:0]   ramp_top  [ltrg_pkg::CHANNELS];
    logic [ltrg_pkg::LEVEL_W-1:0] ramp_bot  [ltrg_pkg::CHANNELS];

    level_result_t expected_levels[$];
    int mismatches;
    int checked;
    int turns;

    // acc * (top - bottom) / 65535 rounded toward minus infinity, plus bottom
    function automatic logic [ltrg_pkg::LEVEL_W-1:0] scaled_level(
        input logic [ltrg_pkg::ACC_W-1:0]   acc,
        input logic [ltrg_pkg::TOP_W-1:0]   top,
        input logic [ltrg_pkg::LEVEL_W-1:0] bot
    );
        longint span;
        longint prod;
        longint quo;
        longint lvl;
        span = longint'(top) - longint'(bot);
        prod = longint'(acc) * span;
        quo  = prod / 65535;
        if (prod < 0 && quo * 65535 != prod) begin
            quo = quo - 1;
        end
        lvl = quo + longint'(bot);
        return lvl[ltrg_pkg::LEVEL_W-1:0];
    endfunction

    task automatic predict_level(
        input logic [ltrg_pkg::CH_W-1:0]   ch,
        input logic                        restart,
        input logic [ltrg_pkg::STEP_W-1:0] nstep,
        input logic [ltrg_pkg::TOP_W-1:0]  ntop,
        input logic [ltrg_pkg::NBOT_W-1:0] nbot
    );
        level_result_t exp_res;
        int idx;
        idx = int'(ch);
        exp_res.channel = ch;
        exp_res.level   = '0;
        exp_res.rising  = 1'b0;
        if (idx < ltrg_pkg::CHANNELS) begin
            if (restart) begin
                ramp_step[idx] = nstep;
                ramp_top[idx]  = ntop;
                ramp_bot[idx]  = {2'b00, nbot};
                ramp_up[idx]   = 1'b1;
                ramp_acc[idx]  = ltrg_pkg::ACC_ZERO;
            end else if (ramp_up[idx]) begin
                if ((ltrg_pkg::ACC_FULL - ramp_acc[idx]) < ramp_step[idx]) begin
                    // would overflow: pin at full, turn down, take new step and bottom
                    ramp_acc[idx]  = ltrg_pkg::ACC_FULL;
                    ramp_up[idx]   = 1'b0;
                    ramp_step[idx] = nstep;
                    ramp_bot[idx]  = {2'b00, nbot};
                    turns++;
                end else begin
                    ramp_acc[idx] = ramp_acc[idx] + ramp_step[idx];
                end
            end else begin
                if (ramp_acc[idx] < ramp_step[idx]) begin
                    ramp_acc[idx]  = ltrg_pkg::ACC_ZERO;
                    ramp_up[idx]   = 1'b1;
                    ramp_step[idx] = nstep;
                    ramp_top[idx]  = ntop;
                    turns++;
                end else begin
                    ramp_acc[idx] = ramp_acc[idx] - ramp_step[idx];
                end
            end
            exp_res.level  = scaled_level(ramp_acc[idx], ramp_top[idx], ramp_bot[idx]);
            exp_res.rising = ramp_up[idx];
        end
        expected_levels.push_back(exp_res);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_result();
        level_result_t exp_res;
        if (expected_levels.size() == 0) begin
            report_mismatch("unexpected result on channel", int'(m_out_channel), -1);
        end else begin
            exp_res = expected_levels.pop_front();
            checked++;
            if (m_out_channel !== exp_res.channel) begin
                report_mismatch("out_channel", int'(m_out_channel), int'(exp_res.channel));
            end
            if (m_level !== exp_res.level) begin
                report_mismatch("level", int'(m_level), int'(exp_res.level));
            end
            if (m_rising !== exp_res.rising) begin
                report_mismatch("rising", int'(m_rising), int'(exp_res.rising));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ltrg_pkg::CHANNELS; i++) begin
                ramp_acc[i]  = ltrg_pkg::ACC_ZERO;
                ramp_up[i]   = 1'b1;
                ramp_step[i] = '0;
                ramp_top[i]  = '0;
                ramp_bot[i]  = '0;
            end
            expected_levels.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_result();
            end
            if (s_valid && s_ready) begin
                predict_level(s_channel, s_restart, s_next_step, s_next_top, s_next_bottom);
            end
        end
        pending      <= expected_levels.size();
        fail_count   <= mismatches;
        result_count <= checked;
        turn_count   <= turns;
    end

endmodule

### bench/tb_led_twinkle_ramp_generator_unit.sv
// top of the twinkle ramp generator bench: clock, reset, stimulus, receiver and verdict
module tb_led_twinkle_ramp_generator_unit;

    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_ITEMS = 1000;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 12;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                              s_valid       = 1'b0;
    logic                              s_ready;
    logic [ltrg_pkg::CH_W-1:0]         s_channel     = '0;
    logic                              s_restart     = 1'b0;
    logic [ltrg_pkg::STEP_W-1:0]       s_next_step   = '0;
    logic [ltrg_pkg::TOP_W-1:0]        s_next_top    = '0;
    logic [ltrg_pkg::NBOT_W-1:0]       s_next_bottom = '0;
    logic                              m_valid;
    logic                              m_ready       = 1'b0;
    logic [ltrg_pkg::CH_W-1:0]         m_out_channel;
    logic [ltrg_pkg::LEVEL_W-1:0]      m_level;
    logic                              m_rising;

    int fail_count;
    int pending;
    int result_count;
    int turn_count;

    int  cycle_count = 0;
    int  hold_ticket = 0;
    int  hold_served = 0;
    int  items_sent = 0;
    int  restarts_sent = 0;
    int  drains = 0;
    bit  armed [ltrg_pkg::CHANNELS];

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    led_twinkle_ramp_generator_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_channel     (s_channel),
        .s_restart     (s_restart),
        .s_next_step   (s_next_step),
        .s_next_top    (s_next_top),
        .s_next_bottom (s_next_bottom),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_level       (m_level),
        .m_rising      (m_rising)
    );

    ltrg_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_channel     (s_channel),
        .s_restart     (s_restart),
        .s_next_step   (s_next_step),
        .s_next_top    (s_next_top),
        .s_next_bottom (s_next_bottom),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_level       (m_level),
        .m_rising      (m_rising),
        .fail_count    (fail_count),
        .pending       (pending),
        .result_count  (result_count),
        .turn_count    (turn_count)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random ready duty that changes per stretch, plus long holds on request
    int rx_hold_left;
    int rx_run_left;
    int rx_duty;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            rx_hold_left = 0;
            rx_run_left  = 0;
            rx_duty      = 100;
        end else begin
            if (hold_ticket != hold_served) begin
                hold_served  = hold_ticket;
                rx_hold_left = LONG_HOLD;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (rx_run_left == 0) begin
                    rx_run_left = $urandom_range(1, 64);
                    case ($urandom_range(0, 3))
                        0: rx_duty = 100;
                        1: rx_duty = 75;
                        2: rx_duty = 40;
                        default: rx_duty = 10;
                    endcase
                end
                rx_run_left--;
                m_ready <= ($urandom_range(0, 99) < rx_duty);
            end
        end
    end

    // valid stays up across back-to-back calls; caller drops it only for a gap, a drain or the end
    task automatic offer_item(
        input logic [ltrg_pkg::CH_W-1:0]   ch,
        input logic                        restart,
        input logic [ltrg_pkg::STEP_W-1:0] nstep,
        input logic [ltrg_pkg::TOP_W-1:0]  ntop,
        input logic [ltrg_pkg::NBOT_W-1:0] nbot
    );
        s_valid       <= 1'b1;
        s_channel     <= ch;
        s_restart     <= restart;
        s_next_step   <= nstep;
        s_next_top    <= ntop;
        s_next_bottom <= nbot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (restart) begin
            restarts_sent++;
            armed[ch] = 1'b1;
        end
    endtask

    // a channel is never stepped before its first restart
    task automatic random_item();
        logic [ltrg_pkg::CH_W-1:0]   ch;
        logic                        restart;
        logic [ltrg_pkg::STEP_W-1:0] nstep;
        logic [ltrg_pkg::TOP_W-1:0]  ntop;
        logic [ltrg_pkg::NBOT_W-1:0] nbot;
        ch      = 2'($urandom_range(0, ltrg_pkg::CHANNELS - 1));
        restart = !armed[ch] || ($urandom_range(0, 39) == 0);
        case ($urandom_range(0, 7))
            0: nstep = 12'($urandom_range(0, 15));
            1: nstep = 12'($urandom);
            default: nstep = 12'($urandom_range(1024, 4095));
        endcase
        if ($urandom_range(0, 9) == 0) begin
            ntop = 8'($urandom);
            nbot = 6'($urandom);
        end else begin
            ntop = 8'($urandom_range(200, 250));
            nbot = 6'($urandom_range(30, 50));
        end
        offer_item(ch, restart, nstep, ntop, nbot);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        drains++;
    endtask

    int sent_random;
    int burst;
    int gap;
    int holds_done;
    int next_hold_at;
    bit drained_mid;

    initial begin
        sent_random  = 0;
        holds_done   = 0;
        next_hold_at = 250;
        drained_mid  = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extreme fields, restart mid-ramp, zero step, top below bottom
        offer_item(2'd0, 1'b1, 12'd4095, 8'd250, 6'd50);
        offer_item(2'd0, 1'b0, 12'd0, 8'd0, 6'd0);
        offer_item(2'd0, 1'b0, 12'hfff, 8'hff, 6'h3f);
        offer_item(2'd0, 1'b0, 12'd1, 8'd200, 6'd30);
        offer_item(2'd1, 1'b1, 12'd0, 8'd200, 6'd30);
        offer_item(2'd1, 1'b0, 12'hfff, 8'd250, 6'd50);
        offer_item(2'd1, 1'b0, 12'd7, 8'd201, 6'd31);
        offer_item(2'd2, 1'b1, 12'd1, 8'd0, 6'h3f);
        offer_item(2'd2, 1'b0, 12'd5, 8'd0, 6'd0);
        offer_item(2'd2, 1'b0, 12'd5, 8'd0, 6'd0);
        offer_item(2'd2, 1'b1, 12'd4095, 8'd0, 6'h3f);
        offer_item(2'd2, 1'b0, 12'd0, 8'hff, 6'd0);
        offer_item(2'd2, 1'b0, 12'd0, 8'hff, 6'd0);
        offer_item(2'd3, 1'b1, 12'd2048, 8'hff, 6'd0);
        offer_item(2'd3, 1'b0, 12'hfff, 8'hff, 6'h3f);
        offer_item(2'd3, 1'b0, 12'd0, 8'd0, 6'd0);
        offer_item(2'd3, 1'b0, 12'h555, 8'haa, 6'h15);
        offer_item(2'd0, 1'b1, 12'd100, 8'd250, 6'd50);
        offer_item(2'd0, 1'b0, 12'haaa, 8'h55, 6'h2a);
        drain_results();

        while (sent_random < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 32);
            if (holds_done < 2 && sent_random >= next_hold_at) begin
                // receiver stops for a long stretch while the sender keeps pushing
                hold_ticket  <= hold_ticket + 1;
                holds_done++;
                next_hold_at += 450;
                burst = 60;
            end
            if (!drained_mid && sent_random >= 500) begin
                drain_results();
                drained_mid = 1'b1;
            end
            repeat (burst) begin
                random_item();
                sent_random++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("summary: %0d transactions sent (%0d restarts), %0d levels checked",
                 items_sent, restarts_sent, result_count);
        $display("summary: %0d ramp turns, %0d long receiver holds, %0d drains to empty",
                 turn_count, holds_done, drains);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
